// File: rtl/core/muxed_frame_notch_filter_assert.svh
// Assertion macros for the muxed frame notch filter.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef MUXED_FRAME_NOTCH_FILTER_ASSERT_SVH
`define MUXED_FRAME_NOTCH_FILTER_ASSERT_SVH

// Condition must hold at every clock edge out of reset.
`define FNF_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define FNF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/fnf_pkg.sv
// Shared types and constants of the muxed frame notch filter.
// No dependencies.
package fnf_pkg;

	localparam int DATA_W = 24;
	localparam int Y_W    = 32;
	localparam int ACC_W  = 64;
	localparam int PROD_W = DATA_W + Y_W;

	// Configuration register indexes.
	localparam logic [2:0] REG_B0 = 3'd0;
	localparam logic [2:0] REG_B1 = 3'd1;
	localparam logic [2:0] REG_B2 = 3'd2;
	localparam logic [2:0] REG_A1 = 3'd3;
	localparam logic [2:0] REG_A2 = 3'd4;

	// Low bits of every command's multiplexer code.
	localparam logic [2:0] MUX_LOW = 3'b111;

	// Result kinds.
	localparam logic KIND_CMD  = 1'b0;
	localparam logic KIND_FILT = 1'b1;

	// Per-channel filter history row.
	typedef struct packed {
		logic signed [DATA_W-1:0] x1;
		logic signed [DATA_W-1:0] x2;
		logic signed [Y_W-1:0]    y1;
		logic signed [Y_W-1:0]    y2;
	} hist_row_t;

	// Control group from the sequencer to the multiply-accumulate unit.
	typedef struct packed {
		logic issue;
		logic clear;
	} mac_ctl_t;

endpackage

// File: rtl/core/muxed_frame_notch_filter.sv
// Channel   | valid     | stall     | payload
// ----------+-----------+-----------+--------------------------------------------
// input     | in_valid  | in_stall  | first_adc_word, second_adc_word, link_up
// result    | out_valid | out_stall | kind, mux_code, channel, filtered_value, last
// config    | cfg_we    | (none)    | cfg_index, cfg_data
//
// An input transaction loads its multiplexer command at once. At a frame end with the
// link up, each of the 2*SLOTS_PER_CONVERTER channels passes in turn through one memory
// read, five products on the shared multiplier, a drain of the last product, rounding
// toward zero with saturation, and an emit that waits out output stall. Reset clears
// slot, sequencer, output valid and history valid bits and loads the default
// coefficients. Inputs stall while filtering or a result is held.
// Depends on fnf_pkg, fnf_frame_mem, fnf_hist_mem, fnf_mac and the assertion header.
module muxed_frame_notch_filter #(
	parameter int SLOTS_PER_CONVERTER = 7,
	parameter int COEF_FRAC_BITS      = 20
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [23:0] first_adc_word,
	input  logic [23:0] second_adc_word,
	input  logic        link_up,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  mux_code,
	output logic [3:0]  channel,
	output logic [23:0] filtered_value,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);

	localparam int NUM_CH = 2 * SLOTS_PER_CONVERTER;
	localparam int SLOT_W = (SLOTS_PER_CONVERTER > 1) ? $clog2(SLOTS_PER_CONVERTER) : 1;
	localparam int CH_W   = $clog2(NUM_CH);
	localparam int DW     = fnf_pkg::DATA_W;
	localparam int YW     = fnf_pkg::Y_W;
	localparam int AW     = fnf_pkg::ACC_W;
	localparam logic [SLOT_W-1:0] SLOT_LAST = SLOT_W'(SLOTS_PER_CONVERTER - 1);
	localparam logic [CH_W-1:0]   CH_LAST   = CH_W'(NUM_CH - 1);
	localparam logic signed [AW-1:0] FRAC_MASK = (AW'(1) <<< COEF_FRAC_BITS) - AW'(1);
	localparam logic signed [AW-1:0] Y_MAX = AW'(64'sh7FFF_FFFF);
	localparam logic signed [AW-1:0] Y_MIN = -AW'(64'sh8000_0000);

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_MAC, S_FIN1, S_FIN2, S_EMIT
	} state_t;

	state_t              state_q;
	logic [SLOT_W-1:0]   slot_q;
	logic [CH_W-1:0]     ch_q;
	logic [SLOT_W-1:0]   ch_slot_q;
	logic                ch_half_q;
	logic [2:0]          step_q;
	logic signed [YW-1:0] y_q;

	logic signed [DW-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  mux_q;
	logic [3:0]  channel_q;
	logic [23:0] value_q;
	logic        last_q;

	logic                 in_acc;
	logic                 out_free;
	logic                 out_load;
	logic                 frame_end;
	logic [SLOT_W-1:0]    slot_next;
	logic [2*DW-1:0]      frame_rdata;
	fnf_pkg::hist_row_t   hist_rdata;
	fnf_pkg::hist_row_t   hist_wdata;
	logic                 hist_we;
	fnf_pkg::mac_ctl_t    mac_ctl;
	logic signed [DW-1:0] mac_coef;
	logic signed [YW-1:0] mac_opnd;
	logic signed [AW-1:0] acc;
	logic signed [AW-1:0] quot;
	logic signed [DW-1:0] x_cur;

	// Output register frees up when empty or being taken this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign in_acc   = in_valid && !in_stall;

	// Load the output register with a command or a filtered value.
	assign out_load = (state_q == S_IDLE && in_acc) || (state_q == S_EMIT && out_free);

	// Slot advance; an out-of-range slot counts as zero.
	always_comb begin
		logic [SLOT_W-1:0] k;
		k = (32'(slot_q) >= SLOTS_PER_CONVERTER) ? '0 : slot_q;
		frame_end = (k == SLOT_LAST);
		slot_next = frame_end ? '0 : k + SLOT_W'(1);
	end

	fnf_frame_mem #(
		.DEPTH(SLOTS_PER_CONVERTER),
		.AW   (SLOT_W),
		.W    (2 * DW)
	) u_frame (
		.clk  (clk),
		.we   (in_acc),
		.waddr((32'(slot_q) >= SLOTS_PER_CONVERTER) ? '0 : slot_q),
		.wdata({second_adc_word, first_adc_word}),
		.re   (state_q == S_RD),
		.raddr(ch_slot_q),
		.rdata(frame_rdata)
	);

	fnf_hist_mem #(
		.DEPTH(NUM_CH),
		.AW   (CH_W)
	) u_hist (
		.clk   (clk),
		.arst_n(arst_n),
		.we    (hist_we),
		.waddr (ch_q),
		.wdata (hist_wdata),
		.re    (state_q == S_RD),
		.raddr (ch_q),
		.rdata (hist_rdata)
	);

	assign x_cur = ch_half_q ? frame_rdata[2*DW-1:DW] : frame_rdata[DW-1:0];

	// Pick one coefficient and operand per product step.
	always_comb begin
		mac_ctl.issue = (state_q == S_MAC);
		mac_ctl.clear = (step_q == 3'd0);
		case (step_q)
			3'd0: begin
				mac_coef = b0_q;
				mac_opnd = YW'(x_cur);
			end
			3'd1: begin
				mac_coef = b1_q;
				mac_opnd = YW'(hist_rdata.x1);
			end
			3'd2: begin
				mac_coef = b2_q;
				mac_opnd = YW'(hist_rdata.x2);
			end
			3'd3: begin
				mac_coef = a1_q;
				mac_opnd = hist_rdata.y1;
			end
			default: begin
				mac_coef = a2_q;
				mac_opnd = hist_rdata.y2;
			end
		endcase
	end

	fnf_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mac_ctl),
		.coef   (mac_coef),
		.operand(mac_opnd),
		.acc    (acc)
	);

	// Truncate toward zero: floor shift, bump up negatives with dropped bits.
	assign quot = (acc >>> COEF_FRAC_BITS)
		+ $signed(AW'(acc[AW-1] && ((acc & FRAC_MASK) != '0)));

	assign hist_we = (state_q == S_EMIT) && out_free;
	always_comb begin
		hist_wdata.x1 = x_cur;
		hist_wdata.x2 = hist_rdata.x1;
		hist_wdata.y1 = y_q;
		hist_wdata.y2 = hist_rdata.y1;
	end

	// Coefficient registers; ignore writes beyond the list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= 24'sd1048576;
			b1_q <= -24'sd1992294;
			b2_q <= 24'sd1048576;
			a1_q <= 24'sd1992294;
			a2_q <= -24'sd943718;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fnf_pkg::REG_B0: b0_q <= cfg_data;
				fnf_pkg::REG_B1: b1_q <= cfg_data;
				fnf_pkg::REG_B2: b2_q <= cfg_data;
				fnf_pkg::REG_A1: a1_q <= cfg_data;
				fnf_pkg::REG_A2: a2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Sequencer and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			slot_q      <= '0;
			ch_q        <= '0;
			ch_slot_q   <= '0;
			ch_half_q   <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Hold a stalled result, drop a taken one, raise on a new load.
			out_valid_q <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						slot_q      <= slot_next;
						ch_q        <= '0;
						ch_slot_q   <= '0;
						ch_half_q   <= 1'b0;
						if (frame_end && link_up) begin
							state_q <= S_RD;
						end
					end
				end
				S_RD: begin
					step_q  <= '0;
					state_q <= S_MAC;
				end
				S_MAC: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd4) begin
						state_q <= S_FIN1;
					end
				end
				S_FIN1: state_q <= S_FIN2;
				S_FIN2: state_q <= S_EMIT;
				S_EMIT: begin
					if (out_free) begin
						if (ch_q == CH_LAST) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= S_RD;
							ch_q    <= ch_q + CH_W'(1);
							if (ch_slot_q == SLOT_LAST) begin
								ch_slot_q <= '0;
								ch_half_q <= 1'b1;
							end else begin
								ch_slot_q <= ch_slot_q + SLOT_W'(1);
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Result payload and rounded, saturated output.
	always_ff @(posedge clk) begin
		if (state_q == S_FIN2) begin
			if (quot > Y_MAX) begin
				y_q <= YW'(Y_MAX);
			end else if (quot < Y_MIN) begin
				y_q <= YW'(Y_MIN);
			end else begin
				y_q <= YW'(quot);
			end
		end
		if (state_q == S_IDLE && in_acc) begin
			kind_q    <= fnf_pkg::KIND_CMD;
			mux_q     <= {5'(slot_next), fnf_pkg::MUX_LOW};
			channel_q <= '0;
			value_q   <= '0;
			last_q    <= !(frame_end && link_up);
		end else if (state_q == S_EMIT && out_free) begin
			kind_q    <= fnf_pkg::KIND_FILT;
			mux_q     <= '0;
			channel_q <= 4'(ch_q);
			value_q   <= y_q[23:0];
			last_q    <= (ch_q == CH_LAST);
		end
	end

	assign out_valid      = out_valid_q;
	assign kind           = kind_q;
	assign mux_code       = mux_q;
	assign channel        = channel_q;
	assign filtered_value = value_q;
	assign last           = last_q;

`include "muxed_frame_notch_filter_assert.svh"

	// A command that is not last means a frame is being filtered.
	`FNF_ASSERT_ALWAYS(a_cmd_opens_frame, !(out_valid_q && kind_q == fnf_pkg::KIND_CMD && !last_q) || state_q != S_IDLE, "command without last but sequencer idle")
	// Each emitted channel steps the channel counter by one.
	`FNF_ASSERT_NEXT(a_ch_step, hist_we && ch_q != CH_LAST, ch_q == $past(ch_q) + CH_W'(1), "channel counter did not advance")
	// History is written back only while a filtered result is loaded.
	`FNF_ASSERT_NEXT(a_hist_emit, hist_we, out_valid_q && kind_q == fnf_pkg::KIND_FILT, "history written without a filtered result")

endmodule

// File: rtl/core/fnf_frame_mem.sv
// Frame sample memory: one row per slot holding both converter words.
// Depends on nothing; synchronous, one write and one read port.
module fnf_frame_mem #(
	parameter int DEPTH = 7,
	parameter int AW    = 3,
	parameter int W     = 48
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/core/fnf_hist_mem.sv
// Filter history memory, one row per channel, with per-row valid bits.
// Depends on fnf_pkg; a row never written reads as zero.
module fnf_hist_mem #(
	parameter int DEPTH = 14,
	parameter int AW    = 4
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  fnf_pkg::hist_row_t wdata,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output fnf_pkg::hist_row_t rdata
);

	fnf_pkg::hist_row_t mem [DEPTH];
	fnf_pkg::hist_row_t raw_q;
	logic [DEPTH-1:0]   vld_q;
	logic               rvld_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			raw_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= vld_q[raddr];
			end
		end
	end

	assign rdata = rvld_q ? raw_q : '0;

endmodule

// File: rtl/core/fnf_mac.sv
// Shared multiply-accumulate unit: registered product, then accumulate.
// Depends on fnf_pkg.
module fnf_mac (
	input  logic                                clk,
	input  logic                                arst_n,
	input  fnf_pkg::mac_ctl_t                   ctl,
	input  logic signed [fnf_pkg::DATA_W-1:0]   coef,
	input  logic signed [fnf_pkg::Y_W-1:0]      operand,
	output logic signed [fnf_pkg::ACC_W-1:0]    acc
);

	logic signed [fnf_pkg::PROD_W-1:0] prod_s1;
	logic                              issue_s1;
	logic                              clear_s1;
	logic signed [fnf_pkg::ACC_W-1:0]  acc_q;

	always_ff @(posedge clk) begin
		prod_s1 <= coef * operand;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			clear_s1 <= 1'b0;
		end else begin
			issue_s1 <= ctl.issue;
			clear_s1 <= ctl.clear;
		end
	end

	// Restart the sum on the first product of a channel.
	always_ff @(posedge clk) begin
		if (issue_s1) begin
			acc_q <= (clear_s1 ? '0 : acc_q) + fnf_pkg::ACC_W'(prod_s1);
		end
	end

	assign acc = acc_q;

endmodule
